// File: hdl/qfei_pkg.sv
// Shared types, constants and helpers for the quaternion escape-time iterator.
`default_nettype none

package qfei_pkg;

  localparam int MAX_ITERATIONS = 256;
  localparam int FRAC_BITS      = 28;
  localparam int COORD_W        = 32;
  localparam int MAG_W          = 36;
  localparam int COUNT_W        = 9;
  localparam int COUNT_MAX      = 511;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int PROD_W         = 2 * COORD_W;
  localparam int CFG_DATA_W     = MAG_W;
  localparam int CFG_INDEX_W    = 3;
  // count reported when the limit is reached
  localparam int LIMIT_COUNT    = (MAX_ITERATIONS > COUNT_MAX) ? COUNT_MAX : MAX_ITERATIONS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic signed [PROD_W-1:0]  wide_t;

  typedef struct packed {
    coord_t r;
    coord_t i;
    coord_t j;
    coord_t k;
  } quat_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_HOLD
  } eng_state_t;

  // one multiplier issue per step; the last step's product goes unused, it updates z and decides
  typedef enum logic [2:0] {
    STEP_SQ_R,
    STEP_SQ_I,
    STEP_SQ_J,
    STEP_SQ_K,
    STEP_X_I,
    STEP_X_J,
    STEP_X_K,
    STEP_DECIDE
  } step_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_JULIA_MODE = 3'd0,
    REG_C_REAL     = 3'd1,
    REG_C_I        = 3'd2,
    REG_C_J        = 3'd3,
    REG_C_K        = 3'd4,
    REG_Z_J_START  = 3'd5,
    REG_Z_K_START  = 3'd6,
    REG_BAILOUT    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

  typedef struct packed {
    count_t count;
    logic   escaped;
    mag_t   magnitude;
  } result_t;

  localparam wide_t WIDE_COORD_MAX = {{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam wide_t WIDE_COORD_MIN = {{(PROD_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v > WIDE_COORD_MAX) begin
      r = WIDE_COORD_MAX[COORD_W-1:0];
    end else if (v < WIDE_COORD_MIN) begin
      r = WIDE_COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/quaternion_fractal_escape_iterator.sv
// Top level: config registers, start selection, result word register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  pixel    | pixel_valid / pixel_stall  | pixel_x, pixel_y (signed Q3.28)
//  result   | result_valid / result_stall| iteration_count, escaped, final_magnitude
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One pixel word holds the engine while it loads, runs N orbit passes (1..256) of
// eight steps each around the single 32x32 multiplier, and hands the result on.
// A new pixel word is taken once the engine has handed its result to the output
// register; a stalled result word holds the next finished result in the engine,
// and pixel_stall stays high until it moves.
// Reset (rst, synchronous) restores the register defaults: julia mode,
// bailout 1.0, all constants zero. cfg_ready is always high.
`default_nettype none

module quaternion_fractal_escape_iterator (
  input  logic                                 clk,
  input  logic                                 rst,
  // pixel channel
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  qfei_pkg::coord_t                     pixel_x,
  input  qfei_pkg::coord_t                     pixel_y,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output qfei_pkg::count_t                     iteration_count,
  output logic                                 escaped,
  output qfei_pkg::mag_t                       final_magnitude,
  // config channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qfei_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [qfei_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import qfei_pkg::*;

  // config registers
  logic    julia_mode;
  coord_t  c_real, c_i, c_j, c_k;
  coord_t  z_j_start, z_k_start;
  mag_t    bailout_limit;

  quat_t       z_init, c_init;
  logic        start, take;
  eng_status_t status;
  result_t     eng_result;
  result_t     out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      julia_mode    <= 1'b1;
      c_real        <= '0;
      c_i           <= '0;
      c_j           <= '0;
      c_k           <= '0;
      z_j_start     <= '0;
      z_k_start     <= '0;
      bailout_limit <= MAG_W'(1) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_JULIA_MODE: julia_mode    <= cfg_data[0];
        REG_C_REAL:     c_real        <= cfg_data[COORD_W-1:0];
        REG_C_I:        c_i           <= cfg_data[COORD_W-1:0];
        REG_C_J:        c_j           <= cfg_data[COORD_W-1:0];
        REG_C_K:        c_k           <= cfg_data[COORD_W-1:0];
        REG_Z_J_START:  z_j_start     <= cfg_data[COORD_W-1:0];
        REG_Z_K_START:  z_k_start     <= cfg_data[COORD_W-1:0];
        REG_BAILOUT:    bailout_limit <= cfg_data[MAG_W-1:0];
      endcase
    end
  end

  // julia: pixel seeds z.r/z.i, c from registers; mandelbrot-type: z = 0, pixel is c.r/c.i, c.j/c.k from registers
  always_comb begin
    if (julia_mode) begin
      z_init = '{r: pixel_x, i: pixel_y, j: z_j_start, k: z_k_start};
      c_init = '{r: c_real, i: c_i, j: c_j, k: c_k};
    end else begin
      z_init = '0;
      c_init = '{r: pixel_x, i: pixel_y, j: c_j, k: c_k};
    end
  end

  assign pixel_stall = !status.idle;
  assign start       = pixel_valid && !pixel_stall;
  // engine result moves into the output register when it is free or draining
  assign take        = status.done && (!result_valid || !result_stall);

  qfei_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .z_init  (z_init),
    .c_init  (c_init),
    .bailout (bailout_limit),
    .take    (take),
    .status  (status),
    .result  (eng_result)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_word <= eng_result;
  end

  assign iteration_count = out_word.count;
  assign escaped         = out_word.escaped;
  assign final_magnitude = out_word.magnitude;

endmodule

`default_nettype wire

// File: hdl/qfei_engine.sv
// Iteration engine: sequencer around one shared 32x32 multiplier.
`default_nettype none

module qfei_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  qfei_pkg::quat_t      z_init,
  input  qfei_pkg::quat_t      c_init,
  input  qfei_pkg::mag_t       bailout,
  input  logic                 take,
  output qfei_pkg::eng_status_t status,
  output qfei_pkg::result_t    result
);
  import qfei_pkg::*;

  eng_state_t          state, state_next;
  step_t               step;
  logic [ITER_W-1:0]   iter;
  quat_t               z, c;
  wide_t               prod;
  logic [PROD_W-1:0]   norm_sum;
  wide_t               acc;
  result_t             res;

  coord_t              op_a, op_b;
  wide_t               sq_term, x_term;
  logic [PROD_W-1:0]   mag_full;
  logic                over, last_iter;
  mag_t                mag_sat;
  count_t              esc_count;

  // operand select per step
  always_comb begin
    unique case (step)
      STEP_SQ_R:   begin op_a = z.r; op_b = z.r; end
      STEP_SQ_I:   begin op_a = z.i; op_b = z.i; end
      STEP_SQ_J:   begin op_a = z.j; op_b = z.j; end
      STEP_SQ_K:   begin op_a = z.k; op_b = z.k; end
      STEP_X_I:    begin op_a = z.r; op_b = z.i; end
      STEP_X_J:    begin op_a = z.r; op_b = z.j; end
      STEP_X_K:    begin op_a = z.r; op_b = z.k; end
      STEP_DECIDE: begin op_a = z.r; op_b = z.r; end
    endcase
  end

  assign sq_term   = prod >>> FRAC_BITS;
  assign x_term    = prod >>> (FRAC_BITS - 1);
  assign mag_full  = norm_sum >> FRAC_BITS;
  assign over      = mag_full > {{(PROD_W-MAG_W){1'b0}}, bailout};
  assign mag_sat   = (mag_full > {{(PROD_W-MAG_W){1'b0}}, {MAG_W{1'b1}}}) ? {MAG_W{1'b1}}
                                                                        : mag_full[MAG_W-1:0];
  assign last_iter = iter == ITER_W'(MAX_ITERATIONS - 1);
  assign esc_count = (32'(iter) > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(iter);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: if (start) state_next = ENG_RUN;
      ENG_RUN:  if (step == STEP_DECIDE && (over || last_iter)) state_next = ENG_HOLD;
      ENG_HOLD: if (take) state_next = ENG_IDLE;
      default:  state_next = ENG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    status.idle = (state == ENG_IDLE);
    status.done = (state == ENG_HOLD);
    result      = res;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      step  <= STEP_SQ_R;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (state == ENG_IDLE && start) begin
        step <= STEP_SQ_R;
        iter <= '0;
      end else if (state == ENG_RUN) begin
        if (step == STEP_DECIDE) begin
          step <= STEP_SQ_R;
          if (!over && !last_iter) iter <= iter + 1'b1;
        end else begin
          step <= step_t'(3'(step + 3'd1));
        end
      end
    end
  end

  // datapath: product issued at step s is consumed at step s+1
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (state == ENG_IDLE && start) begin
      z        <= z_init;
      c        <= c_init;
      norm_sum <= '0;
      acc      <= PROD_W'(c_init.r);
    end else if (state == ENG_RUN) begin
      unique case (step)
        STEP_SQ_R: ;
        STEP_SQ_I: begin
          norm_sum <= norm_sum + prod;
          acc      <= acc + sq_term;
        end
        STEP_SQ_J, STEP_SQ_K, STEP_X_I: begin
          norm_sum <= norm_sum + prod;
          acc      <= acc - sq_term;
        end
        STEP_X_J: z.i <= sat_coord(x_term + PROD_W'(c.i));
        STEP_X_K: z.j <= sat_coord(x_term + PROD_W'(c.j));
        STEP_DECIDE: begin
          z.k      <= sat_coord(x_term + PROD_W'(c.k));
          z.r      <= sat_coord(acc);
          norm_sum <= '0;
          acc      <= PROD_W'(c.r);
          if (over) begin
            res.count     <= esc_count;
            res.escaped   <= 1'b1;
            res.magnitude <= mag_sat;
          end else if (last_iter) begin
            res.count     <= COUNT_W'(LIMIT_COUNT);
            res.escaped   <= 1'b0;
            res.magnitude <= mag_sat;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_step_parked: assert property (@(posedge clk) disable iff (rst)
    state != ENG_RUN |-> step == STEP_SQ_R)
    else $error("sequencer step moved outside run");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ENG_IDLE)
    else $error("start while engine busy");

  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ENG_HOLD && !res.escaped) |-> res.count == COUNT_W'(LIMIT_COUNT))
    else $error("non-escaped result without limit count");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state == ENG_RUN |-> 32'(iter) < 32'(MAX_ITERATIONS))
    else $error("iteration counter past limit");
`endif

endmodule

`default_nettype wire
